[design/imd_pkg.sv]
// shared types, status codes and the known message type table for the deframer
// no dependencies; imd_front, imd_back and the top refer to this package by scoped names
package imd_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       chunk_last;
	} in_item_t;

	typedef logic [1:0] status_t;

	localparam status_t ST_ACCEPTED = 2'd0;
	localparam status_t ST_UNKNOWN  = 2'd1;
	localparam status_t ST_MISMATCH = 2'd2;

	// completed frame header as it leaves the front end
	typedef struct packed {
		logic [7:0]  msg_type;
		logic [15:0] locate_code;
		logic [15:0] track_ref;
		logic [47:0] timestamp;
		logic [15:0] frame_length;
		status_t     status;
	} frame_rec_t;

	typedef struct packed {
		logic [7:0]  msg_type;
		logic [15:0] locate_code;
		logic [15:0] track_ref;
		logic [47:0] timestamp;
		logic [15:0] frame_length;
		status_t     status;
		logic [31:0] message_count;
	} out_item_t;

	localparam int MSG_COUNT_W = 32;

	// fixed payload length of each known type, zero when the type is unknown
	function automatic logic [7:0] known_length(input logic [7:0] t);
		logic [7:0] len;
		len = 8'd0;
		case (t)
			"S": len = 8'd12;
			"R": len = 8'd39;
			"H": len = 8'd25;
			"Y": len = 8'd20;
			"L": len = 8'd26;
			"V": len = 8'd35;
			"W": len = 8'd12;
			"K": len = 8'd28;
			"A": len = 8'd36;
			"F": len = 8'd40;
			"E": len = 8'd31;
			"C": len = 8'd36;
			"X": len = 8'd23;
			"D": len = 8'd19;
			"U": len = 8'd35;
			"P": len = 8'd44;
			"Q": len = 8'd40;
			"B": len = 8'd19;
			"I": len = 8'd50;
			"N": len = 8'd20;
			"J": len = 8'd35;
			default: len = 8'd0;
		endcase
		return len;
	endfunction

endpackage

[design/imd_queue.sv]
// small first-in first-out queue of flat words, used between the deframer stages
// no package dependency
module imd_queue #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[design/imd_front.sv]
// front end: length framing, header capture and type classification per byte
// depends on imd_pkg
module imd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  imd_pkg::in_item_t  item,
	input  logic               stall,
	output logic               rec_push,
	output imd_pkg::frame_rec_t rec
);

	typedef enum logic [1:0] {
		PH_LEN_HI,
		PH_LEN_LO,
		PH_BODY,
		PH_HALT
	} phase_t;

	phase_t      phase_q;
	logic [7:0]  len_hi_q;
	logic [15:0] len_q;
	logic [15:0] idx_q;
	logic [7:0]  type_q;
	logic [15:0] locate_q;
	logic [15:0] track_q;
	logic [47:0] time_q;

	logic [7:0]  b;
	logic        accept;
	logic        last_byte;
	logic [7:0]  type_n;
	logic [15:0] locate_n;
	logic [15:0] track_n;
	logic [47:0] time_n;
	logic [7:0]  want;
	logic [15:0] len_next;
	imd_pkg::status_t status;

	assign b         = item.data_byte;
	assign accept    = push && !stall;
	assign last_byte = ({1'b0, idx_q} + 17'd1) == {1'b0, len_q};
	assign len_next  = {len_hi_q, b};

	// header fields with the current byte merged in
	always_comb begin
		type_n   = type_q;
		locate_n = locate_q;
		track_n  = track_q;
		time_n   = time_q;
		case (idx_q)
			16'd0:   type_n         = b;
			16'd1:   locate_n[15:8] = b;
			16'd2:   locate_n[7:0]  = b;
			16'd3:   track_n[15:8]  = b;
			16'd4:   track_n[7:0]   = b;
			16'd5:   time_n[47:40]  = b;
			16'd6:   time_n[39:32]  = b;
			16'd7:   time_n[31:24]  = b;
			16'd8:   time_n[23:16]  = b;
			16'd9:   time_n[15:8]   = b;
			16'd10:  time_n[7:0]    = b;
			default: time_n         = time_q;
		endcase
	end

	always_comb begin
		want = imd_pkg::known_length(type_n);
		if (want == 8'd0) begin
			status = imd_pkg::ST_UNKNOWN;
		end else if ({8'd0, want} != len_q) begin
			status = imd_pkg::ST_MISMATCH;
		end else begin
			status = imd_pkg::ST_ACCEPTED;
		end
	end

	assign rec_push = accept && (phase_q == PH_BODY) && last_byte;

	always_comb begin
		rec.msg_type     = type_n;
		rec.locate_code  = locate_n;
		rec.track_ref    = track_n;
		rec.timestamp    = time_n;
		rec.frame_length = len_q;
		rec.status       = status;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_LEN_HI;
			len_hi_q <= '0;
			len_q    <= '0;
			idx_q    <= '0;
			type_q   <= '0;
			locate_q <= '0;
			track_q  <= '0;
			time_q   <= '0;
		end else if (accept) begin
			case (phase_q)
				PH_LEN_HI: begin
					len_hi_q <= b;
					phase_q  <= PH_LEN_LO;
				end
				PH_LEN_LO: begin
					len_q    <= len_next;
					idx_q    <= '0;
					type_q   <= '0;
					locate_q <= '0;
					track_q  <= '0;
					time_q   <= '0;
					// zero length frames are skipped
					phase_q  <= (len_next == 16'd0) ? PH_LEN_HI : PH_BODY;
				end
				PH_BODY: begin
					type_q   <= type_n;
					locate_q <= locate_n;
					track_q  <= track_n;
					time_q   <= time_n;
					if (last_byte) begin
						idx_q   <= '0;
						phase_q <= (status == imd_pkg::ST_MISMATCH) ? PH_HALT : PH_LEN_HI;
					end else begin
						idx_q <= idx_q + 16'd1;
					end
				end
				default: phase_q <= PH_HALT;
			endcase
		end
	end

	a_rec_status_valid: assert property (@(posedge clk) disable iff (!arst_n)
		rec_push |-> rec.status != 2'd3)
		else $error("front pushed a record with an undefined status");

	a_mismatch_halts: assert property (@(posedge clk) disable iff (!arst_n)
		rec_push && rec.status == imd_pkg::ST_MISMATCH |=> phase_q == PH_HALT)
		else $error("length mismatch did not halt the framer");

	a_halt_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HALT |=> phase_q == PH_HALT && !rec_push)
		else $error("framer left the halted state without reset");

endmodule

[design/imd_back.sv]
// back end: accepted message counter and the result queue
// depends on imd_pkg and imd_queue
module imd_back #(
	parameter int unsigned COUNT_WIDTH = 32,
	parameter int unsigned OUT_DEPTH   = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  imd_pkg::frame_rec_t rec,
	input  logic                rec_empty,
	output logic                rec_pop,
	output imd_pkg::out_item_t  result,
	output logic                empty,
	input  logic                pop
);

	localparam int unsigned EXT_W = (COUNT_WIDTH > imd_pkg::MSG_COUNT_W) ?
		COUNT_WIDTH : imd_pkg::MSG_COUNT_W;

	logic [COUNT_WIDTH-1:0] count_q;
	logic [COUNT_WIDTH-1:0] count_n;
	logic [EXT_W-1:0]       count_ext;
	logic                   out_full;
	logic                   bump;
	imd_pkg::out_item_t     out_w;

	assign rec_pop = !rec_empty && !out_full;
	// saturating count of accepted known messages
	assign bump    = rec_pop && (rec.status == imd_pkg::ST_ACCEPTED) && !(&count_q);
	assign count_n = bump ? count_q + 1'b1 : count_q;
	assign count_ext = EXT_W'(count_n);

	always_comb begin
		out_w.msg_type      = rec.msg_type;
		out_w.locate_code   = rec.locate_code;
		out_w.track_ref     = rec.track_ref;
		out_w.timestamp     = rec.timestamp;
		out_w.frame_length  = rec.frame_length;
		out_w.status        = rec.status;
		out_w.message_count = count_ext[imd_pkg::MSG_COUNT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_n;
		end
	end

	imd_queue #(
		.WIDTH($bits(imd_pkg::out_item_t)),
		.DEPTH(OUT_DEPTH)
	) u_out_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (rec_pop),
		.wdata (out_w),
		.full  (out_full),
		.pop   (pop),
		.rdata (result),
		.empty (empty)
	);

	a_count_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> count_q >= $past(count_q))
		else $error("message count went backwards");

	a_count_only_accepted: assert property (@(posedge clk) disable iff (!arst_n)
		!(rec_pop && rec.status == imd_pkg::ST_ACCEPTED) |=> count_q == $past(count_q))
		else $error("message count moved without an accepted message");

endmodule

[design/itch_message_deframer_top.sv]
// itch message deframer: one byte transfer per cycle while full is low
// a frame's result passes through the front-to-back queue and then the result queue before it reaches the result ports
// length bytes and zero length frames give no result; after a length mismatch bytes
// are still taken but dropped until reset; full is raised only while the
// front-to-back queue is full
// asynchronous active-low reset clears framing, counter and both queues
module itch_message_deframer_top #(
	parameter int unsigned COUNT_WIDTH = 32,
	parameter int unsigned MID_DEPTH   = 2,
	parameter int unsigned OUT_DEPTH   = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  imd_pkg::in_item_t  item,
	output logic               full,
	input  logic               pop,
	output imd_pkg::out_item_t result,
	output logic               empty
);

	logic                             rec_push;
	imd_pkg::frame_rec_t              rec_in;
	logic [$bits(imd_pkg::frame_rec_t)-1:0] rec_flat;
	imd_pkg::frame_rec_t              rec_out;
	logic                             rec_empty;
	logic                             rec_pop;
	logic                             mid_full;

	assign full    = mid_full;
	assign rec_out = rec_flat;

	imd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.item    (item),
		.stall   (mid_full),
		.rec_push(rec_push),
		.rec     (rec_in)
	);

	imd_queue #(
		.WIDTH($bits(imd_pkg::frame_rec_t)),
		.DEPTH(MID_DEPTH)
	) u_mid_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (rec_push),
		.wdata (rec_in),
		.full  (mid_full),
		.pop   (rec_pop),
		.rdata (rec_flat),
		.empty (rec_empty)
	);

	imd_back #(
		.COUNT_WIDTH(COUNT_WIDTH),
		.OUT_DEPTH  (OUT_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.rec      (rec_out),
		.rec_empty(rec_empty),
		.rec_pop  (rec_pop),
		.result   (result),
		.empty    (empty),
		.pop      (pop)
	);

endmodule

[tb/sv/itch_message_deframer_checker.sv]
// checker for the itch message deframer: predicts one header per completed frame
// and compares it with every result transfer; depends on imd_pkg only
module itch_message_deframer_checker #(
	parameter int unsigned COUNT_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  imd_pkg::in_item_t  item,
	input  logic               full,
	input  logic               pop,
	input  imd_pkg::out_item_t result,
	input  logic               empty,
	output int                 errors,
	output int                 waiting
);

	typedef enum logic [1:0] {
		FR_LEN_HI,
		FR_LEN_LO,
		FR_BODY,
		FR_HALT
	} framer_phase_t;

	// letter and fixed payload length of every known message type
	localparam int NUM_KNOWN = 21;
	localparam logic [NUM_KNOWN*16-1:0] KNOWN_TYPES = {
		"S", 8'd12, "R", 8'd39, "H", 8'd25, "Y", 8'd20, "L", 8'd26, "V", 8'd35,
		"W", 8'd12, "K", 8'd28, "A", 8'd36, "F", 8'd40, "E", 8'd31, "C", 8'd36,
		"X", 8'd23, "D", 8'd19, "U", 8'd35, "P", 8'd44, "Q", 8'd40, "B", 8'd19,
		"I", 8'd50, "N", 8'd20, "J", 8'd35
	};

	framer_phase_t            phase;
	logic [7:0]               len_hi;
	logic [15:0]              frame_len;
	int unsigned              body_idx;
	logic [7:0]               type_byte;
	logic [15:0]              locate;
	logic [15:0]              tracking;
	logic [47:0]              stamp;
	logic [COUNT_WIDTH-1:0]   accepted;
	imd_pkg::out_item_t       expected_hdrs[$];
	imd_pkg::out_item_t       want;
	imd_pkg::out_item_t       fresh;
	int                       fail_count;

	assign errors = fail_count;

	initial begin
		fail_count = 0;
		waiting = 0;
	end

	function automatic int unsigned fixed_length(input logic [7:0] t);
		logic [15:0] entry;
		for (int i = 0; i < NUM_KNOWN; i++) begin
			entry = KNOWN_TYPES[i*16 +: 16];
			if (entry[15:8] == t)
				return entry[7:0];
		end
		return 0;
	endfunction

	// one byte through the framer; returns 1 when a frame completes
	function automatic bit advance_framer(input logic [7:0] b,
			output imd_pkg::out_item_t hdr);
		int unsigned want_len;
		hdr = '0;
		case (phase)
			FR_LEN_HI: begin
				len_hi = b;
				phase = FR_LEN_LO;
				return 1'b0;
			end
			FR_LEN_LO: begin
				frame_len = {len_hi, b};
				body_idx = 0;
				type_byte = '0;
				locate = '0;
				tracking = '0;
				stamp = '0;
				phase = (frame_len == 16'd0) ? FR_LEN_HI : FR_BODY;
				return 1'b0;
			end
			FR_HALT: return 1'b0;
			default: ;
		endcase

		case (body_idx)
			0: type_byte = b;
			1: locate[15:8] = b;
			2: locate[7:0] = b;
			3: tracking[15:8] = b;
			4: tracking[7:0] = b;
			5, 6, 7, 8, 9, 10: stamp[(10 - body_idx)*8 +: 8] = b;
			default: ;
		endcase
		body_idx++;
		if (body_idx < frame_len)
			return 1'b0;

		want_len = fixed_length(type_byte);
		if (want_len == 0) begin
			hdr.status = imd_pkg::ST_UNKNOWN;
			phase = FR_LEN_HI;
		end else if (want_len != frame_len) begin
			hdr.status = imd_pkg::ST_MISMATCH;
			phase = FR_HALT;
		end else begin
			hdr.status = imd_pkg::ST_ACCEPTED;
			if (accepted != '1)
				accepted++;
			phase = FR_LEN_HI;
		end
		body_idx = 0;
		hdr.msg_type = type_byte;
		hdr.locate_code = locate;
		hdr.track_ref = tracking;
		hdr.timestamp = stamp;
		hdr.frame_length = frame_len;
		hdr.message_count = 32'(accepted);
		return 1'b1;
	endfunction

	task automatic check_field(input string name, input logic [63:0] exp_val,
			input logic [63:0] act_val);
		if (exp_val !== act_val) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_val,
				act_val);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase = FR_LEN_HI;
			len_hi = '0;
			frame_len = '0;
			body_idx = 0;
			type_byte = '0;
			locate = '0;
			tracking = '0;
			stamp = '0;
			accepted = '0;
			expected_hdrs.delete();
		end else begin
			if (pop && !empty) begin
				if (expected_hdrs.size() == 0) begin
					fail_count++;
					$display("%0t: result transfer with no frame pending, expected none, got %p",
						$time, result);
				end else begin
					want = expected_hdrs.pop_front();
					check_field("msg_type", want.msg_type, result.msg_type);
					check_field("locate_code", want.locate_code, result.locate_code);
					check_field("track_ref", want.track_ref, result.track_ref);
					check_field("timestamp", want.timestamp, result.timestamp);
					check_field("frame_length", want.frame_length, result.frame_length);
					check_field("status", want.status, result.status);
					check_field("message_count", want.message_count, result.message_count);
				end
			end
			if (push && !full) begin
				if (advance_framer(item.data_byte, fresh))
					expected_hdrs = {expected_hdrs, fresh};
			end
		end
		waiting = expected_hdrs.size();
	end

endmodule

[tb/sv/itch_message_deframer_top_tb.sv]
// testbench top for the itch message deframer: clock, reset, byte stream and result drain
// depends on imd_pkg, itch_message_deframer_top and itch_message_deframer_checker
module itch_message_deframer_top_tb;

	localparam int unsigned COUNT_W = 32;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               push;
	imd_pkg::in_item_t  item;
	logic               full;
	logic               pop;
	imd_pkg::out_item_t result;
	logic               empty;
	int                 chk_errors;
	int                 chk_waiting;

	bit                 tx_idle;
	bit                 hold_rx;
	int unsigned        bytes_sent;
	logic [7:0]         known_letters[$];

	itch_message_deframer_top #(
		.COUNT_WIDTH(COUNT_W)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.item  (item),
		.full  (full),
		.pop   (pop),
		.result(result),
		.empty (empty)
	);

	itch_message_deframer_checker #(
		.COUNT_WIDTH(COUNT_W)
	) i_chk (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.item   (item),
		.full   (full),
		.pop    (pop),
		.result (result),
		.empty  (empty),
		.errors (chk_errors),
		.waiting(chk_waiting)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#20000000;
		$display("TB_ERROR");
		$finish;
	end

	// mostly back to back, some short gaps, a few long ones
	function automatic int unsigned tx_gap();
		int unsigned roll;
		if (!tx_idle)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			return 0;
		if (roll < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_byte(input logic [7:0] b);
		int unsigned gap;
		gap = tx_gap();
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		item <= '{data_byte: b, chunk_last: 1'($urandom_range(0, 1))};
		do @(posedge clk); while (full);
		bytes_sent++;
	endtask

	// fill < 0 gives random payload, otherwise every byte after the type is fill
	task automatic send_frame(input logic [15:0] len, input logic [7:0] kind,
			input int fill);
		logic [7:0] b;
		tx_idle = ($urandom_range(0, 3) != 0);
		send_byte(len[15:8]);
		send_byte(len[7:0]);
		for (int i = 0; i < len; i++) begin
			if (i == 0)
				b = kind;
			else if (fill < 0)
				b = 8'($urandom);
			else
				b = 8'(fill);
			send_byte(b);
		end
	endtask

	function automatic logic [7:0] pick_known();
		return known_letters[$urandom_range(0, known_letters.size() - 1)];
	endfunction

	function automatic logic [7:0] pick_unknown();
		logic [7:0] t;
		do t = 8'($urandom); while (imd_pkg::known_length(t) != 0);
		return t;
	endfunction

	task automatic send_known(input logic [7:0] k, input int fill);
		send_frame(16'(imd_pkg::known_length(k)), k, fill);
	endtask

	// result side: random stalls plus one long hold-off to back the block up
	initial begin
		int unsigned stall_left;
		int unsigned mode_left;
		bit          rx_idle;
		bit          hold_taken;
		stall_left = 0;
		mode_left = 0;
		rx_idle = 1'b0;
		hold_taken = 1'b0;
		pop <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_rx && !hold_taken) begin
				hold_taken = 1'b1;
				pop <= 1'b0;
				repeat (400) @(posedge clk);
			end else begin
				if (mode_left == 0) begin
					rx_idle = ($urandom_range(0, 3) != 0);
					mode_left = $urandom_range(50, 200);
				end
				mode_left--;
				if (stall_left == 0 && rx_idle && $urandom_range(0, 99) < 25)
					stall_left = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 3)
						: $urandom_range(10, 40);
				if (stall_left != 0) begin
					pop <= 1'b0;
					stall_left--;
				end else begin
					pop <= 1'b1;
				end
			end
		end
	end

	initial begin
		int unsigned roll;
		int unsigned random_start;
		arst_n <= 1'b0;
		push <= 1'b0;
		item <= '0;
		hold_rx = 1'b0;
		bytes_sent = 0;
		for (int c = 0; c < 256; c++)
			if (imd_pkg::known_length(8'(c)) != 0)
				known_letters = {known_letters, 8'(c)};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero length, all ones and all zeros, every known type, short frames
		send_frame(16'd0, 8'h00, 0);
		send_known("S", 8'hff);
		send_known("S", 8'h00);
		send_frame(16'd0, 8'h00, 0);
		foreach (known_letters[i])
			send_known(known_letters[i], -1);
		send_frame(16'd1, pick_unknown(), -1);
		send_frame(16'd3, pick_unknown(), -1);
		send_frame(16'd5, 8'hff, 8'hff);
		send_frame(16'd7, pick_unknown(), -1);
		send_frame(16'd11, 8'h00, 8'hff);
		send_frame(16'd0, 8'h00, 0);
		// length with a nonzero high byte
		send_frame(16'h0105, pick_unknown(), -1);

		// random: mostly good known frames, some unknown and zero length frames
		hold_rx = 1'b1;
		random_start = bytes_sent;
		while (bytes_sent - random_start < 400) begin
			roll = $urandom_range(0, 99);
			if (roll < 65)
				send_known(pick_known(), -1);
			else if (roll < 85)
				send_frame(16'($urandom_range(1, 60)), pick_unknown(), -1);
			else if (roll < 93)
				send_frame(16'($urandom_range(1, 10)), pick_unknown(), -1);
			else
				send_frame(16'd0, 8'h00, 0);
		end

		// wrong length on a known type halts the framer; the bytes after it are dropped
		send_frame(16'(imd_pkg::known_length("S") + 1), "S", -1);
		repeat (6) send_byte(8'($urandom));
		push <= 1'b0;

		while (chk_waiting != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (chk_errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
